// ----- rtl/core/zfap_pkg.sv -----
// Shared types and constants for the Zstandard frame anatomy parser.
// Depends on nothing; used by zfap_parser and the top level.
`timescale 1ns / 1ps
`default_nettype none
package zfap_pkg;

  localparam int unsigned NSTAT = 22;
  localparam int unsigned AMT_W = 22;

  localparam logic [4:0] ST_BLOCKS = 5'd0;
  localparam logic [4:0] ST_FHDR   = 5'd1;
  localparam logic [4:0] ST_BHDR   = 5'd2;
  localparam logic [4:0] ST_LIT    = 5'd3;
  localparam logic [4:0] ST_SEQ    = 5'd7;
  localparam logic [4:0] ST_NSEQ   = 5'd8;
  localparam logic [4:0] ST_LLM    = 5'd9;
  localparam logic [4:0] ST_OFM    = 5'd13;
  localparam logic [4:0] ST_MLM    = 5'd17;
  localparam logic [4:0] ST_TOTAL  = 5'd21;
  localparam logic [4:0] ST_LAST   = 5'd21;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOT_ZSTD = 2'd1;
  localparam logic [1:0] STATUS_RESERVED = 2'd2;
  localparam logic [1:0] STATUS_MALFORM  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [4:0]  stat_id;
    logic [47:0] stat_value;
    logic [1:0]  status;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic [NSTAT-1:0][AMT_W-1:0] inc;
    logic                        done;
    logic [1:0]                  status;
  } step_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/zfap_parser.sv -----
// Byte-wise frame and block header walker; reports counter increments per byte.
// Depends on zfap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zfap_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire zfap_pkg::in_t item_i,
  output zfap_pkg::step_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3, PH_DESC, PH_FHSKIP, PH_BHDR,
    PH_BSKIP, PH_LHDR, PH_LPAY, PH_SHDR, PH_MODE, PH_REST, PH_DONE, PH_ERR
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [20:0] skip_q, skip_d;
  logic [39:0] hdr_q, hdr_d;
  logic [20:0] bsl_q, bsl_d;
  logic        last_q, last_d;
  logic [1:0]  err_q, err_d;
  logic [2:0]  got_q, got_d;

  always_comb begin
    logic [39:0] hdr_g;
    logic [2:0]  got_g;
    logic [7:0]  b, h0;
    logic [35:0] hv;
    logic [1:0]  lt, sf;
    logic [2:0]  hb;
    logic [19:0] pay;
    logic [20:0] bdec;
    logic [16:0] nseq;
    logic [1:0]  need;
    logic        blk_last;
    logic [1:0]  fcs, dct;
    logic [3:0]  fl, dl;

    b = item_i.data_byte;
    hdr_g = hdr_q;
    got_g = got_q;
    if (got_q < 3'd5) begin
      case (got_q)
        3'd0: hdr_g[7:0]   = b;
        3'd1: hdr_g[15:8]  = b;
        3'd2: hdr_g[23:16] = b;
        3'd3: hdr_g[31:24] = b;
        default: hdr_g[39:32] = b;
      endcase
      got_g = got_q + 3'd1;
    end
    h0 = hdr_g[7:0];
    hv = hdr_g[39:4];
    lt = h0[1:0];
    sf = h0[3:2];
    bdec = bsl_q - 21'd1;
    blk_last = last_q;
    pay = '0;
    hb = 3'd1;
    nseq = '0;
    need = 2'd1;
    fcs = b[7:6];
    dct = b[1:0];
    fl = '0;
    dl = '0;

    phase_d = phase_q;
    skip_d = skip_q;
    hdr_d = hdr_q;
    bsl_d = bsl_q;
    last_d = last_q;
    err_d = err_q;
    got_d = got_q;
    rsp_o = '0;

    if (step_i && item_i.byte_present) begin
      rsp_o.inc[zfap_pkg::ST_TOTAL] = zfap_pkg::AMT_W'(1);
      unique case (phase_q)
        PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3: begin
          logic [7:0] m;
          case (phase_q)
            PH_MAGIC0: m = 8'h28;
            PH_MAGIC1: m = 8'hB5;
            PH_MAGIC2: m = 8'h2F;
            default:   m = 8'hFD;
          endcase
          if (b != m) begin
            if (err_q == zfap_pkg::STATUS_OK) err_d = zfap_pkg::STATUS_NOT_ZSTD;
            phase_d = PH_ERR;
          end else begin
            rsp_o.inc[zfap_pkg::ST_FHDR] = zfap_pkg::AMT_W'(1);
            phase_d = phase_e'(phase_q + 4'd1);
          end
        end
        PH_DESC: begin
          case (fcs)
            2'd0: fl = b[5] ? 4'd1 : 4'd0;
            2'd1: fl = 4'd2;
            2'd2: fl = 4'd4;
            default: fl = 4'd8;
          endcase
          case (dct)
            2'd0: dl = 4'd0;
            2'd1: dl = 4'd1;
            2'd2: dl = 4'd2;
            default: dl = 4'd4;
          endcase
          rsp_o.inc[zfap_pkg::ST_FHDR] = zfap_pkg::AMT_W'(1);
          skip_d = 21'(fl) + 21'(dl) + (b[5] ? 21'd0 : 21'd1);
          if (skip_d == '0) begin
            hdr_d = '0; got_d = '0; phase_d = PH_BHDR;
          end else phase_d = PH_FHSKIP;
        end
        PH_FHSKIP, PH_BSKIP, PH_LPAY: begin
          if (phase_q == PH_FHSKIP) rsp_o.inc[zfap_pkg::ST_FHDR] = zfap_pkg::AMT_W'(1);
          if (skip_q != '0) skip_d = skip_q - 21'd1;
          if (skip_d == '0) begin
            if (phase_q == PH_BSKIP && last_q) phase_d = PH_DONE;
            else begin
              hdr_d = '0; got_d = '0;
              phase_d = (phase_q == PH_LPAY) ? PH_SHDR : PH_BHDR;
            end
          end
        end
        PH_BHDR: begin
          hdr_d = hdr_g; got_d = got_g;
          if (got_g >= 3'd3) begin
            rsp_o.inc[zfap_pkg::ST_BHDR] = zfap_pkg::AMT_W'(3);
            last_d = hdr_g[0];
            blk_last = hdr_g[0];
            if (hdr_g[2:1] == 2'd3) begin
              if (err_q == zfap_pkg::STATUS_OK) err_d = zfap_pkg::STATUS_RESERVED;
              phase_d = PH_ERR;
            end else begin
              rsp_o.inc[zfap_pkg::ST_BLOCKS] = zfap_pkg::AMT_W'(1);
              if (hdr_g[2:1] == 2'd0) begin
                skip_d = hdr_g[23:3];
                if (hdr_g[23:3] == '0) begin
                  if (blk_last) phase_d = PH_DONE;
                  else begin hdr_d = '0; got_d = '0; phase_d = PH_BHDR; end
                end else phase_d = PH_BSKIP;
              end else if (hdr_g[2:1] == 2'd1) begin
                skip_d = 21'd1;
                phase_d = PH_BSKIP;
              end else begin
                bsl_d = hdr_g[23:3];
                hdr_d = '0; got_d = '0; phase_d = PH_LHDR;
              end
            end
          end
        end
        PH_LHDR, PH_SHDR, PH_MODE: begin
          if (bsl_q == '0) begin
            if (err_q == zfap_pkg::STATUS_OK) err_d = zfap_pkg::STATUS_MALFORM;
            phase_d = PH_ERR;
          end else begin
            bsl_d = bdec;
            if (phase_q == PH_LHDR) begin
              hdr_d = hdr_g; got_d = got_g;
              if (!lt[1]) hb = (sf == 2'd1) ? 3'd2 : ((sf == 2'd3) ? 3'd3 : 3'd1);
              else hb = (sf[1] == 1'b0) ? 3'd3 : ((sf == 2'd2) ? 3'd4 : 3'd5);
              if (got_g >= hb) begin
                if (!lt[1]) begin
                  if (hb == 3'd1) pay = 20'(h0[7:3]);
                  else if (hb == 3'd2) pay = 20'(hv[11:0]);
                  else pay = hv[19:0];
                  if (lt[0]) pay = 20'd1;
                end else begin
                  if (!sf[1]) pay = 20'(hv[19:10]);
                  else if (sf == 2'd2) pay = 20'(hv[27:14]);
                  else pay = 20'(hv[35:18]);
                end
                if (21'(pay) > bdec) begin
                  if (err_q == zfap_pkg::STATUS_OK) err_d = zfap_pkg::STATUS_MALFORM;
                  phase_d = PH_ERR;
                end else begin
                  rsp_o.inc[zfap_pkg::ST_LIT + 5'(lt)] =
                    zfap_pkg::AMT_W'(pay) + zfap_pkg::AMT_W'(hb);
                  rsp_o.inc[zfap_pkg::ST_SEQ] = zfap_pkg::AMT_W'(bdec - 21'(pay));
                  bsl_d = bdec - 21'(pay);
                  skip_d = 21'(pay);
                  if (pay == '0) begin
                    hdr_d = '0; got_d = '0; phase_d = PH_SHDR;
                  end else phase_d = PH_LPAY;
                end
              end
            end else if (phase_q == PH_SHDR) begin
              hdr_d = hdr_g; got_d = got_g;
              need = !h0[7] ? 2'd1 : ((h0 != 8'hFF) ? 2'd2 : 2'd3);
              if (got_g >= 3'(need)) begin
                if (need == 2'd1) nseq = 17'(h0);
                else if (need == 2'd2) nseq = 17'({h0[6:0], hdr_g[15:8]});
                else nseq = 17'(hdr_g[23:8]) + 17'h7F00;
                rsp_o.inc[zfap_pkg::ST_NSEQ] = zfap_pkg::AMT_W'(nseq);
                if (nseq != '0) phase_d = PH_MODE;
                else if (bdec != '0) phase_d = PH_REST;
                else if (last_q) phase_d = PH_DONE;
                else begin hdr_d = '0; got_d = '0; phase_d = PH_BHDR; end
              end
            end else begin
              rsp_o.inc[zfap_pkg::ST_LLM + 5'(b[7:6])] = zfap_pkg::AMT_W'(1);
              rsp_o.inc[zfap_pkg::ST_OFM + 5'(b[5:4])] = zfap_pkg::AMT_W'(1);
              rsp_o.inc[zfap_pkg::ST_MLM + 5'(b[3:2])] = zfap_pkg::AMT_W'(1);
              if (bdec != '0) phase_d = PH_REST;
              else if (last_q) phase_d = PH_DONE;
              else begin hdr_d = '0; got_d = '0; phase_d = PH_BHDR; end
            end
          end
        end
        PH_REST: begin
          if (bsl_q != '0) bsl_d = bdec;
          if (bsl_d == '0) begin
            if (last_q) phase_d = PH_DONE;
            else begin hdr_d = '0; got_d = '0; phase_d = PH_BHDR; end
          end
        end
        default: ;
      endcase
    end

    // end of file: report final status, then drop all parse state
    if (step_i && item_i.end_of_file) begin
      rsp_o.done = 1'b1;
      if (err_d == zfap_pkg::STATUS_OK && phase_d < PH_DESC)
        rsp_o.status = zfap_pkg::STATUS_NOT_ZSTD;
      else rsp_o.status = err_d;
      phase_d = PH_MAGIC0;
      skip_d = '0; hdr_d = '0; bsl_d = '0; last_d = 1'b0; err_d = '0; got_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC0;
      skip_q  <= '0;
      hdr_q   <= '0;
      bsl_q   <= '0;
      last_q  <= 1'b0;
      err_q   <= '0;
      got_q   <= '0;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      hdr_q   <= hdr_d;
      bsl_q   <= bsl_d;
      last_q  <= last_d;
      err_q   <= err_d;
      got_q   <= got_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/zstd_frame_anatomy_parser_unit.sv -----
// Top level of the Zstandard frame anatomy parser: statistics counters and dump.
// Depends on zfap_pkg and zfap_parser.
//
// Usage:
//   in channel  (in_valid_i / in_ready_o, payload in_i): one request per byte
//     of the file; byte_present low with end_of_file high is a bare end marker.
//   out channel (out_valid_o / out_ready_i, payload out_o): at end of file the
//     22 counters come out in index order, last_result on the final one, or a
//     single error request with the status code.
//   Throughput: one byte per clock but for a waiting end of file. Each byte
//     updates the parse state and the counters in the cycle it is accepted; the
//     counter adders set that path. The end-of-file request sets the dump flag,
//     and the first dump request is then loaded into the output register; a
//     dump then drains at one request per cycle while the receiver takes them.
//   The counters are copied into a snapshot bank and cleared at end of file,
//     so bytes of the next file are accepted while the dump drains. Only a
//     second end-of-file request waits (in_ready_o low) until the dump is done.
//   A receiver stall holds the output register and the dump index.
//   Reset: parser returns to the first magic byte, counters clear to zero,
//     no dump is pending. Counters saturate at 2^COUNT_WIDTH-1; the low 48
//     bits are reported.
`timescale 1ns / 1ps
`default_nettype none
module zstd_frame_anatomy_parser_unit #(
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire zfap_pkg::in_t  in_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      zfap_pkg::out_t out_o
);

  logic                step;
  zfap_pkg::step_rsp_t rsp;

  logic [COUNT_WIDTH-1:0] cnt_q  [zfap_pkg::NSTAT];
  logic [COUNT_WIDTH-1:0] cnt_nx [zfap_pkg::NSTAT];
  logic [COUNT_WIDTH-1:0] snap_q [zfap_pkg::NSTAT];

  logic       dump_act_q;
  logic [4:0] dump_idx_q;
  logic [1:0] dump_err_q;
  logic       load;
  logic [63:0] snap_ext;

  // hold a second end of file until the current dump has drained
  assign in_ready_o = !(in_i.end_of_file && dump_act_q);
  assign step       = in_valid_i && in_ready_o;

  zfap_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_i),
    .rsp_o  (rsp)
  );

  // saturating add of this byte's increments
  always_comb begin
    for (int i = 0; i < zfap_pkg::NSTAT; i++) begin
      logic [COUNT_WIDTH:0] sum;
      sum = {1'b0, cnt_q[i]} + (COUNT_WIDTH+1)'(rsp.inc[i]);
      cnt_nx[i] = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < zfap_pkg::NSTAT; i++) cnt_q[i] <= '0;
    end else begin
      for (int i = 0; i < zfap_pkg::NSTAT; i++) cnt_q[i] <= rsp.done ? '0 : cnt_nx[i];
    end
  end

  // snapshot includes the final byte's effect
  always_ff @(posedge clk_i) begin
    if (rsp.done) begin
      for (int i = 0; i < zfap_pkg::NSTAT; i++) snap_q[i] <= cnt_nx[i];
    end
  end

  assign load     = dump_act_q && (!out_valid_o || out_ready_i);
  assign snap_ext = 64'(snap_q[dump_idx_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_act_q  <= 1'b0;
      dump_idx_q  <= '0;
      dump_err_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (load) begin
        out_valid_o <= 1'b1;
        // advance through the bank, or stop after the single error request
        if (dump_err_q != zfap_pkg::STATUS_OK || dump_idx_q == zfap_pkg::ST_LAST)
          dump_act_q <= 1'b0;
        else dump_idx_q <= dump_idx_q + 5'd1;
      end
      if (rsp.done) begin
        dump_act_q <= 1'b1;
        dump_idx_q <= '0;
        dump_err_q <= rsp.status;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (dump_err_q != zfap_pkg::STATUS_OK) begin
        out_o.stat_id     <= '0;
        out_o.stat_value  <= '0;
        out_o.status      <= dump_err_q;
        out_o.last_result <= 1'b1;
      end else begin
        out_o.stat_id     <= dump_idx_q;
        out_o.stat_value  <= snap_ext[47:0];
        out_o.status      <= zfap_pkg::STATUS_OK;
        out_o.last_result <= (dump_idx_q == zfap_pkg::ST_LAST);
      end
    end
  end

endmodule
`default_nettype wire
